// ----- rtl/ahm_pkg.sv -----
// Shared types, constants and helpers for the authority host matcher.
`default_nettype none
package ahm_pkg;

    localparam int DEF_MAX_HOST_LEN = 256;
    localparam int POS_W            = 9;
    localparam int PORT_W           = 17;
    localparam int OP_W             = 2;
    localparam int BYTE_W           = 8;

    localparam logic [POS_W-1:0]  POS_MAX  = 9'd511;
    localparam logic [PORT_W-1:0] PORT_MAX = 17'd65535;

    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_BYTE = 2'd1;
    localparam logic [OP_W-1:0] OP_END  = 2'd2;

    localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFS  = 8'h20;

    // Word handed from the address stage to the compare/parse stage.
    typedef struct packed {
        logic              is_byte;
        logic              is_end;
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  pos;
    } t_s1_word;

    typedef struct packed {
        logic host_match;
        logic auth_valid;
    } t_verdict;

    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            r = c + CASE_OFS;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/ahm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module ahm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/ahm_parse.sv -----
// Compare and parse stage: per-authority flags, phase tracking and verdict.
`default_nettype none
module ahm_parse
    import ahm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire t_s1_word          i_word,
    input  wire logic [BYTE_W-1:0] i_exp_byte,
    input  wire logic [POS_W-1:0]  i_used_len,
    output t_verdict               o_verdict
);

    typedef enum logic [6:0] {
        PH_START     = 7'b0000001,
        PH_BR_OPEN   = 7'b0000010,
        PH_BR_IN     = 7'b0000100,
        PH_BR_CLOSED = 7'b0001000,
        PH_PLAIN     = 7'b0010000,
        PH_PORT      = 7'b0100000,
        PH_BAD       = 7'b1000000
    } t_phase;

    t_phase            r_phase, n_phase;
    logic              r_full_eq, n_full_eq;
    logic              r_host_eq, n_host_eq;
    logic [POS_W-1:0]  r_host_len, n_host_len;
    logic [PORT_W-1:0] r_port, n_port;
    logic              r_port_dig, n_port_dig;

    logic              same;
    logic              in_host;
    logic              is_colon;
    logic [19:0]       port_cand;
    logic [POS_W:0]    pos_inc;
    logic              valid;
    logic [POS_W-1:0]  end_host_len;

    assign is_colon  = (i_word.data == CH_COLON);
    assign same      = (i_word.pos < i_used_len) &&
                       (fold_case(i_exp_byte) == fold_case(i_word.data));
    assign in_host   = (r_phase == PH_BR_OPEN) || (r_phase == PH_BR_IN) ||
                       (((r_phase == PH_START) || (r_phase == PH_PLAIN)) && !is_colon);
    assign port_cand = ({3'd0, r_port} * 20'd10) + {12'd0, i_word.data - CH_ZERO};
    assign pos_inc   = {1'b0, i_word.pos} + {{POS_W{1'b0}}, 1'b1};

    // Verdict for an end word, from the flags left by the earlier bytes.
    always_comb begin
        end_host_len = r_host_len;
        case (r_phase)
            PH_PLAIN: begin
                valid        = 1'b1;
                end_host_len = i_word.pos;
            end
            PH_BR_CLOSED: valid = 1'b1;
            PH_PORT:      valid = r_port_dig;
            default:      valid = 1'b0;
        endcase
        if (i_used_len == '0) begin
            o_verdict.host_match = 1'b1;
        end else if (i_word.pos == '0) begin
            o_verdict.host_match = 1'b0;
        end else begin
            o_verdict.host_match = (r_full_eq && (i_word.pos == i_used_len)) ||
                                   (valid && r_host_eq && (end_host_len == i_used_len));
        end
        o_verdict.auth_valid = valid;
    end

    always_comb begin
        n_phase    = r_phase;
        n_full_eq  = r_full_eq;
        n_host_eq  = r_host_eq;
        n_host_len = r_host_len;
        n_port     = r_port;
        n_port_dig = r_port_dig;
        if (i_fire && i_word.is_end) begin
            n_phase    = PH_START;
            n_full_eq  = 1'b1;
            n_host_eq  = 1'b1;
            n_host_len = '0;
            n_port     = '0;
            n_port_dig = 1'b0;
        end else if (i_fire && i_word.is_byte) begin
            if (!same) begin
                n_full_eq = 1'b0;
            end
            if (in_host && !same) begin
                n_host_eq = 1'b0;
            end
            case (r_phase)
                PH_START: begin
                    if (i_word.data == CH_LBRACK) begin
                        n_phase = PH_BR_OPEN;
                    end else if (is_colon) begin
                        n_phase = PH_BAD;
                    end else begin
                        n_phase = PH_PLAIN;
                    end
                end
                PH_BR_OPEN: begin
                    n_phase = (i_word.data == CH_RBRACK) ? PH_BAD : PH_BR_IN;
                end
                PH_BR_IN: begin
                    if (i_word.data == CH_RBRACK) begin
                        n_host_len = pos_inc[POS_W] ? POS_MAX : pos_inc[POS_W-1:0];
                        n_phase    = PH_BR_CLOSED;
                    end
                end
                PH_BR_CLOSED: begin
                    n_phase = is_colon ? PH_PORT : PH_BAD;
                end
                PH_PLAIN: begin
                    if (is_colon) begin
                        n_host_len = i_word.pos;
                        n_phase    = PH_PORT;
                    end
                end
                PH_PORT: begin
                    if (i_word.data >= CH_ZERO && i_word.data <= CH_NINE) begin
                        if (port_cand > {3'd0, PORT_MAX}) begin
                            n_phase = PH_BAD;
                        end else begin
                            n_port     = port_cand[PORT_W-1:0];
                            n_port_dig = 1'b1;
                        end
                    end else begin
                        n_phase = PH_BAD;
                    end
                end
                default: n_phase = PH_BAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_START;
            r_full_eq  <= 1'b1;
            r_host_eq  <= 1'b1;
            r_host_len <= '0;
            r_port     <= '0;
            r_port_dig <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_full_eq  <= n_full_eq;
            r_host_eq  <= n_host_eq;
            r_host_len <= n_host_len;
            r_port     <= n_port;
            r_port_dig <= n_port_dig;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/authority_host_matcher.sv -----
// Top level of the authority host matcher: address stage, store and result register.
//
// Input channel (i_valid/o_ready) takes one word per cycle: load words write
// the expected host into a byte store, authority words stream the authority,
// and an end word produces one result on the output channel (o_valid/i_ready).
// Load and authority words produce no result; operation 3 is dropped.
// A word is accepted when i_valid and o_ready are both high; a result is taken
// when o_valid and i_ready are both high.
// Throughput: one word per cycle while o_ready is high. An accepted end word is
// registered for the compare stage, then its result in the result register (o_valid).
// The store read for an authority byte is issued at acceptance using the
// running byte position, so compare and parse run in the following cycle.
// When the receiver stalls with a result pending and another end word reaches
// the compare stage, o_ready drops until the result register frees.
// Reset (synchronous, active low) clears expected_len, the byte position and
// all parse flags; store contents are undefined until loaded. i_cfg_we writes
// expected_len from i_cfg_data; the user must write it only while idle, unenforced.
`default_nettype none
module authority_host_matcher
    import ahm_pkg::*;
#(
    parameter int MAX_HOST_LEN = DEF_MAX_HOST_LEN
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [POS_W-1:0]  i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [OP_W-1:0]   i_operation,
    input  wire logic [7:0]        i_load_index,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic                   o_matches_res,
    output logic                   o_authority_valid
);

    localparam int AW = (MAX_HOST_LEN > 1) ? $clog2(MAX_HOST_LEN) : 1;

    logic [POS_W-1:0]  r_exp_len;
    logic [POS_W-1:0]  r_pos;
    logic              r_s1_v;
    t_s1_word          r_s1;
    logic              r_ov;
    t_verdict          r_res;

    logic              in_fire;
    logic              s1_hold;
    logic              s1_fire;
    logic [POS_W-1:0]  used_len;
    logic              ram_we;
    logic [AW+7:0]     waddr_ext;
    logic [AW+POS_W-1:0] raddr_ext;
    logic [BYTE_W-1:0] exp_byte;
    t_verdict          verdict;

    assign s1_hold = r_s1_v && r_s1.is_end && r_ov && !i_ready;
    assign o_ready = !s1_hold;
    assign in_fire = i_valid && o_ready;
    assign s1_fire = r_s1_v && !s1_hold;

    assign used_len = (32'(r_exp_len) > MAX_HOST_LEN) ? POS_W'(MAX_HOST_LEN) : r_exp_len;

    assign waddr_ext = {{AW{1'b0}}, i_load_index};
    assign raddr_ext = {{AW{1'b0}}, r_pos};
    assign ram_we    = in_fire && (i_operation == OP_LOAD) &&
                       (32'(i_load_index) < MAX_HOST_LEN);

    ahm_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_HOST_LEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr_ext[AW-1:0]),
        .i_wdata (i_data_byte),
        .i_raddr (raddr_ext[AW-1:0]),
        .o_rdata (exp_byte)
    );

    ahm_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (s1_fire),
        .i_word     (r_s1),
        .i_exp_byte (exp_byte),
        .i_used_len (used_len),
        .o_verdict  (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_len <= '0;
            r_pos     <= '0;
            r_s1_v    <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_exp_len <= i_cfg_data;
            end
            if (in_fire && i_operation == OP_BYTE && r_pos != POS_MAX) begin
                r_pos <= r_pos + POS_W'(1);
            end else if (in_fire && i_operation == OP_END) begin
                r_pos <= '0;
            end
            if (o_ready) begin
                r_s1_v <= in_fire && (i_operation == OP_BYTE || i_operation == OP_END);
            end
            if (s1_fire && r_s1.is_end) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_s1.is_byte <= (i_operation == OP_BYTE);
            r_s1.is_end  <= (i_operation == OP_END);
            r_s1.data    <= i_data_byte;
            r_s1.pos     <= r_pos;
        end
        if (s1_fire && r_s1.is_end) begin
            r_res <= verdict;
        end
    end

    assign o_valid           = r_ov;
    assign o_matches_res     = r_res.host_match;
    assign o_authority_valid = r_res.auth_valid;

endmodule
`default_nettype wire

// ----- bench/ahm_verdict_checker.sv -----
// Verdict checker for the authority host matcher: tracks accepted words, predicts and compares.
`timescale 1ns / 1ps
module ahm_verdict_checker
    import ahm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [POS_W-1:0]  cfg_data,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire logic [OP_W-1:0]   in_op,
    input  wire logic [7:0]        in_index,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire logic              out_matches,
    input  wire logic              out_auth_valid,
    output int                     mismatch_count,
    output int                     verdicts_pending,
    output int                     verdicts_checked
);

    localparam int PRINT_CAP = 40;

    typedef enum logic [2:0] {
        ST_START,
        ST_BR_OPEN,
        ST_BR_IN,
        ST_BR_CLOSED,
        ST_PLAIN,
        ST_PORT,
        ST_BAD
    } t_parse_state;

    logic [BYTE_W-1:0] host_store [DEF_MAX_HOST_LEN];
    logic [POS_W-1:0]  host_len_cfg;
    logic [POS_W-1:0]  auth_pos;
    t_parse_state      parse_st;
    logic              full_same;
    logic              host_same;
    logic [POS_W-1:0]  host_span;
    logic [PORT_W-1:0] port_acc;
    logic              port_digit_seen;
    t_verdict          verdict_q [$];
    int                mismatches = 0;
    int                checked    = 0;

    function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? (c | CASE_OFS) : c;
    endfunction

    // lengths above the store size act as the store size
    function automatic int used_len();
        return (int'(host_len_cfg) > DEF_MAX_HOST_LEN) ? DEF_MAX_HOST_LEN : int'(host_len_cfg);
    endfunction

    task automatic clear_stream();
        auth_pos        = '0;
        parse_st        = ST_START;
        full_same       = 1'b1;
        host_same       = 1'b1;
        host_span       = '0;
        port_acc        = '0;
        port_digit_seen = 1'b0;
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP) begin
            $display("MISMATCH at verdict %0d: %s", checked, msg);
        end
        mismatches++;
    endtask

    task automatic take_authority_byte(input logic [BYTE_W-1:0] c);
        logic same;
        logic in_host;
        int   digit;
        same = (int'(auth_pos) < used_len()) &&
               (to_lower(host_store[auth_pos[7:0]]) == to_lower(c));
        if (!same) begin
            full_same = 1'b0;
        end
        in_host = (parse_st == ST_BR_OPEN) || (parse_st == ST_BR_IN) ||
                  ((parse_st == ST_START || parse_st == ST_PLAIN) && c != CH_COLON);
        if (in_host && !same) begin
            host_same = 1'b0;
        end
        case (parse_st)
            ST_START: begin
                if (c == CH_LBRACK) parse_st = ST_BR_OPEN;
                else if (c == CH_COLON) parse_st = ST_BAD;
                else parse_st = ST_PLAIN;
            end
            ST_BR_OPEN: begin
                if (c == CH_RBRACK) parse_st = ST_BAD;
                else parse_st = ST_BR_IN;
            end
            ST_BR_IN: begin
                if (c == CH_RBRACK) begin
                    // host includes both brackets
                    host_span = (auth_pos == POS_MAX) ? POS_MAX : auth_pos + 1'b1;
                    parse_st  = ST_BR_CLOSED;
                end
            end
            ST_BR_CLOSED: begin
                if (c == CH_COLON) parse_st = ST_PORT;
                else parse_st = ST_BAD;
            end
            ST_PLAIN: begin
                if (c == CH_COLON) begin
                    host_span = auth_pos;
                    parse_st  = ST_PORT;
                end
            end
            ST_PORT: begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    digit = int'(c - CH_ZERO);
                    if (int'(port_acc) > (int'(PORT_MAX) - digit) / 10) begin
                        parse_st = ST_BAD;
                    end else begin
                        port_acc        = port_acc * 10 + digit;
                        port_digit_seen = 1'b1;
                    end
                end else begin
                    parse_st = ST_BAD;
                end
            end
            default: parse_st = ST_BAD;
        endcase
        if (auth_pos != POS_MAX) begin
            auth_pos = auth_pos + 1'b1;
        end
    endtask

    task automatic finish_authority(output t_verdict v);
        int   n;
        logic ok;
        n = used_len();
        case (parse_st)
            ST_PLAIN: begin
                host_span = auth_pos;
                ok        = 1'b1;
            end
            ST_BR_CLOSED: ok = 1'b1;
            ST_PORT:      ok = port_digit_seen;
            default:      ok = 1'b0;
        endcase
        v.auth_valid = ok;
        if (n == 0) begin
            v.host_match = 1'b1;
        end else if (auth_pos == '0) begin
            v.host_match = 1'b0;
        end else begin
            v.host_match = (full_same && int'(auth_pos) == n) ||
                           (ok && host_same && int'(host_span) == n);
        end
        clear_stream();
    endtask

    always @(posedge clk) begin : watch
        t_verdict want;
        if (!rst_n) begin
            verdict_q.delete();
            host_len_cfg = '0;
            clear_stream();
        end else begin
            // a result always belongs to an end word taken on an earlier edge
            if (out_valid && out_ready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("result word with no verdict pending");
                end else begin
                    want = verdict_q.pop_front();
                    if (out_matches !== want.host_match) begin
                        report_mismatch($sformatf("matches_res got %b want %b",
                                                  out_matches, want.host_match));
                    end
                    if (out_auth_valid !== want.auth_valid) begin
                        report_mismatch($sformatf("authority_valid got %b want %b",
                                                  out_auth_valid, want.auth_valid));
                    end
                    checked++;
                end
            end
            if (cfg_we) begin
                host_len_cfg = cfg_data;
            end
            if (in_valid && in_ready) begin
                case (in_op)
                    OP_LOAD: host_store[in_index] = in_byte;
                    OP_BYTE: take_authority_byte(in_byte);
                    OP_END: begin
                        finish_authority(want);
                        verdict_q.push_back(want);
                    end
                    default: ;
                endcase
            end
        end
        mismatch_count   <= mismatches;
        verdicts_pending <= verdict_q.size();
        verdicts_checked <= checked;
    end

endmodule

// ----- bench/authority_host_matcher_tb.sv -----
// Testbench top for the authority host matcher: stimulus, output-side flow control and verdict.
`timescale 1ns / 1ps
module authority_host_matcher_tb;
    import ahm_pkg::*;

    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int STALL_LEN    = 300;
    localparam int RANDOM_WORDS = 450;
    localparam int SEGMENTS     = 9;
    localparam int SETTLE       = 4;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_cfg_we     = 1'b0;
    logic [POS_W-1:0]  i_cfg_data   = '0;
    logic              i_valid      = 1'b0;
    logic [OP_W-1:0]   i_operation  = OP_LOAD;
    logic [7:0]        i_load_index = '0;
    logic [BYTE_W-1:0] i_data_byte  = '0;
    logic              i_ready      = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic              o_matches_res;
    logic              o_authority_valid;

    int mismatch_count;
    int verdicts_pending;
    int verdicts_checked;

    logic [7:0] host_img [DEF_MAX_HOST_LEN];
    int         host_len_cur = 0;
    logic [7:0] auth_buf [$];
    int         tx_idle_pct   = 0;
    int         rx_idle_pct   = 0;
    int         words_sent    = 0;
    int         settings_used = 0;
    int         cycle_count   = 0;
    logic       stall_req     = 1'b0;
    int         stall_count   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    authority_host_matcher uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_operation       (i_operation),
        .i_load_index      (i_load_index),
        .i_data_byte       (i_data_byte),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_matches_res     (o_matches_res),
        .o_authority_valid (o_authority_valid)
    );

    ahm_verdict_checker verdict_chk (
        .clk              (i_clk),
        .rst_n            (i_rst_n),
        .cfg_we           (i_cfg_we),
        .cfg_data         (i_cfg_data),
        .in_valid         (i_valid),
        .in_ready         (o_ready),
        .in_op            (i_operation),
        .in_index         (i_load_index),
        .in_byte          (i_data_byte),
        .out_valid        (o_valid),
        .out_ready        (i_ready),
        .out_matches      (o_matches_res),
        .out_auth_valid   (o_authority_valid),
        .mismatch_count   (mismatch_count),
        .verdicts_pending (verdicts_pending),
        .verdicts_checked (verdicts_checked)
    );

    // receiver: random back-pressure, or a long hold counted here
    always @(posedge i_clk) begin
        if (stall_req && stall_count < STALL_LEN) begin
            i_ready     <= 1'b0;
            stall_count <= stall_count + 1;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
            if (!stall_req) begin
                stall_count <= 0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts pending", cycle_count,
                     verdicts_pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [7:0] mix_case(input logic [7:0] c);
        logic [7:0] low;
        low = c | 8'h20;
        if (low >= CH_LOW_A && low <= CH_LOW_Z && $urandom_range(1) == 1) begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    task automatic send_word(input logic [OP_W-1:0] op, input logic [7:0] idx,
                             input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_operation  <= op;
        i_load_index <= idx;
        i_data_byte  <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        words_sent++;
    endtask

    // stop offering words until every verdict is out and the pipe is empty
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (verdicts_pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_expected_len(input int v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v[POS_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        settings_used++;
    endtask

    task automatic load_host(input int len, input bit bracket);
        logic [7:0] b;
        int         r;
        for (int i = 0; i < len; i++) begin
            if (bracket && i == 0) begin
                b = CH_LBRACK;
            end else if (bracket && i == len - 1) begin
                b = CH_RBRACK;
            end else if (bracket) begin
                r = $urandom_range(15);
                if ($urandom_range(3) == 0) b = CH_COLON;
                else if (r < 10) b = CH_ZERO + 8'(r);
                else b = mix_case(CH_LOW_A + 8'(r - 10));
            end else begin
                r = $urandom_range(9);
                if (r == 0) b = CH_DOT;
                else if (r == 1) b = CH_DASH;
                else if (r < 4) b = CH_ZERO + 8'($urandom_range(9));
                else b = mix_case(CH_LOW_A + 8'($urandom_range(25)));
            end
            send_word(OP_LOAD, i[7:0], b);
            host_img[i] = b;
        end
        host_len_cur = len;
    endtask

    task automatic append_port();
        int         v;
        int         r;
        logic [7:0] digits [$];
        r = $urandom_range(7);
        if (r == 0) return;  // empty port
        if (r == 1) v = $urandom_range(999999, 65536);
        else if (r == 2) v = 65535 + $urandom_range(1);
        else if (r == 3) begin
            repeat ($urandom_range(3, 1)) auth_buf.push_back(CH_ZERO);
            v = $urandom_range(99);
        end else v = $urandom_range(65535);
        do begin
            digits.push_front(CH_ZERO + 8'(v % 10));
            v = v / 10;
        end while (v > 0);
        foreach (digits[i]) auth_buf.push_back(digits[i]);
    endtask

    // kind < 0 picks a random shape
    task automatic build_authority(input int kind_req);
        int kind;
        int n;
        int r;
        auth_buf.delete();
        kind = (kind_req < 0) ? $urandom_range(9) : kind_req;
        if (kind_req < 0 && host_len_cur > 16 && $urandom_range(3) != 0) kind = 6;
        if (kind == 9) auth_buf.push_back(CH_COLON);
        if (kind != 6 && kind != 8) begin
            for (int i = 0; i < host_len_cur; i++) auth_buf.push_back(mix_case(host_img[i]));
        end
        case (kind)
            2, 3: begin
                auth_buf.push_back(CH_COLON);
                append_port();
            end
            4: begin
                if (auth_buf.size() > 0) begin
                    n = $urandom_range(auth_buf.size() - 1);
                    if ($urandom_range(1) == 1) auth_buf[n] = auth_buf[n] ^ 8'h20;
                    else auth_buf[n] = 8'($urandom_range(255));
                end
            end
            5: begin
                if ($urandom_range(1) == 1 && auth_buf.size() > 0) void'(auth_buf.pop_back());
                else auth_buf.push_back(mix_case(CH_LOW_A + 8'($urandom_range(25))));
            end
            6: begin
                repeat ($urandom_range(8)) begin
                    r = $urandom_range(9);
                    case (r)
                        0: auth_buf.push_back(CH_COLON);
                        1: auth_buf.push_back(CH_LBRACK);
                        2: auth_buf.push_back(CH_RBRACK);
                        3: auth_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
                        4: auth_buf.push_back(CH_LOW_A);
                        5: auth_buf.push_back(CH_UPPER_A);
                        6: auth_buf.push_back(8'h40);
                        7: auth_buf.push_back(8'h60);
                        8: auth_buf.push_back(8'h7B);
                        default: auth_buf.push_back(8'($urandom_range(255)));
                    endcase
                end
            end
            7: begin
                auth_buf.push_back(CH_COLON);
                append_port();
                auth_buf.push_back(CH_COLON);
                auth_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
            end
            8: begin
                auth_buf.push_back(CH_LBRACK);
                repeat ($urandom_range(4)) begin
                    r = $urandom_range(16);
                    if (r == 16) auth_buf.push_back(CH_COLON);
                    else if (r < 10) auth_buf.push_back(CH_ZERO + 8'(r));
                    else auth_buf.push_back(mix_case(CH_LOW_A + 8'(r - 10)));
                end
                if ($urandom_range(4) != 0) auth_buf.push_back(CH_RBRACK);
                r = $urandom_range(3);
                if (r == 1) begin
                    auth_buf.push_back(CH_COLON);
                    append_port();
                end else if (r == 2) begin
                    auth_buf.push_back(CH_COLON);
                end else if (r == 3) begin
                    auth_buf.push_back(CH_LOW_A + 8'($urandom_range(25)));
                end
            end
            default: ;
        endcase
    endtask

    task automatic stream_authority();
        foreach (auth_buf[i]) begin
            if ($urandom_range(39) == 0) begin
                send_word(OP_IGNORED, 8'($urandom_range(255)), 8'($urandom_range(255)));
            end
            send_word(OP_BYTE, 8'($urandom_range(255)), auth_buf[i]);
        end
        send_word(OP_END, 8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    task automatic stream_text(input string s);
        auth_buf.delete();
        for (int i = 0; i < s.len(); i++) auth_buf.push_back(s[i]);
        stream_authority();
    endtask

    initial begin : stimulus
        string      directed_host;
        logic [7:0] b;
        int         idx;
        int         len;
        int         cfg;
        int         goal;
        int         seg;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 20;
        rx_idle_pct = 55;

        // every store entry gets written before any compare can read it
        for (int i = 0; i < DEF_MAX_HOST_LEN; i++) begin
            b = 8'($urandom_range(255));
            send_word(OP_LOAD, i[7:0], b);
            host_img[i] = b;
        end

        // directed: empty authority with zero length, ignored op, small host checks
        send_word(OP_END, 8'hFF, 8'h00);
        send_word(OP_IGNORED, 8'hA5, 8'h5A);
        directed_host = "x.Y";
        for (int i = 0; i < directed_host.len(); i++) begin
            send_word(OP_LOAD, i[7:0], directed_host[i]);
            host_img[i] = directed_host[i];
        end
        host_len_cur = directed_host.len();
        write_expected_len(host_len_cur);
        stream_text("X.y");
        stream_text("x.y:0");
        stream_text(":1");
        stream_text("[]");

        for (seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 3) begin
                tx_idle_pct = 55;
                rx_idle_pct = 20;
            end else if (seg == 6) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (seg == 2) begin
                load_host(DEF_MAX_HOST_LEN, 1'b0);
                cfg = DEF_MAX_HOST_LEN;
            end else if (seg == 5) begin
                load_host(DEF_MAX_HOST_LEN, 1'b1);
                cfg = (1 << POS_W) - 1;
            end else begin
                len = $urandom_range(12, 1);
                load_host(len, (len >= 3) && ($urandom_range(1) == 1));
                if (seg == 7) cfg = 0;
                else if (seg == 4) cfg = len + 1;
                else cfg = len;
            end
            write_expected_len(cfg);

            if (seg == 2 || seg == 5) begin
                build_authority(0);
                stream_authority();
                build_authority(2);
                stream_authority();
            end
            if (seg == 2) begin
                // past the position limit: can never match
                build_authority(0);
                while (auth_buf.size() < 520) auth_buf.push_back(8'($urandom_range(255)));
                stream_authority();
            end
            if (seg == 6) begin
                // hold the output side while the sender keeps going
                stall_req <= 1'b1;
                repeat (10) begin
                    build_authority(-1);
                    stream_authority();
                end
                while (stall_count < STALL_LEN) @(posedge i_clk);
                stall_req <= 1'b0;
            end

            goal = words_sent + RANDOM_WORDS / SEGMENTS;
            while (words_sent < goal) begin
                if ($urandom_range(19) == 0) begin
                    send_word(OP_IGNORED, 8'($urandom_range(255)), 8'($urandom_range(255)));
                end else if ($urandom_range(29) == 0) begin
                    idx = $urandom_range(DEF_MAX_HOST_LEN - 1);
                    b   = 8'($urandom_range(255));
                    send_word(OP_LOAD, idx[7:0], b);
                    host_img[idx] = b;
                end else begin
                    build_authority(-1);
                    stream_authority();
                end
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (verdicts_pending != 0) @(posedge i_clk);
        repeat (2 * SETTLE) @(posedge i_clk);

        $display("run covered %0d words and %0d verdicts over %0d expected_len settings,",
                 words_sent, verdicts_checked, settings_used);
        $display("with a full store fill, a long output hold and idle drains between settings");
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ahm_pkg.sv
rtl/ahm_ram.sv
rtl/ahm_parse.sv
rtl/authority_host_matcher.sv
bench/ahm_verdict_checker.sv
bench/authority_host_matcher_tb.sv
